// ===== design/bmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpq_pkg - shared definitions for the bounded max-priority queue
// Default sizes, request and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package bmpq_pkg;

  // default sizes
  localparam int DEPTH_DEF  = 16;
  localparam int PRIO_W_DEF = 8;
  localparam int HND_W_DEF  = 16;

  // capacity register
  localparam int             CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  // request kinds (carried on tuser)
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // controller state
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } bmpq_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // write the new entry into the cell at the fill position
    logic del;   // close the gap left by the removed entry
  } bmpq_ctrl_t;

endpackage

// ===== design/bmpq_cell.sv =====
// ----------------------------------------------------------------------------
// bmpq_cell - one storage cell of the priority queue chain
// Holds one entry, forwards a running-maximum token to its upper neighbour
// and takes its upper neighbour's entry when a removal closes the gap.
// ----------------------------------------------------------------------------
module bmpq_cell
  import bmpq_pkg::*;
#(
  parameter int PRIO_W = PRIO_W_DEF,
  parameter int HND_W  = HND_W_DEF,
  parameter int IDX_W  = 4,
  parameter int CNT_W  = 5,
  parameter int POS    = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bmpq_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]  count,
  input  logic [IDX_W-1:0]  sel_idx,
  input  logic [PRIO_W-1:0] wr_prio,
  input  logic [HND_W-1:0]  wr_hnd,
  input  logic [PRIO_W-1:0] nb_prio,
  input  logic [HND_W-1:0]  nb_hnd,
  input  logic              tok_in_found,
  input  logic [PRIO_W-1:0] tok_in_prio,
  input  logic [HND_W-1:0]  tok_in_hnd,
  input  logic [IDX_W-1:0]  tok_in_idx,
  output logic [PRIO_W-1:0] prio,
  output logic [HND_W-1:0]  hnd,
  output logic              tok_out_found,
  output logic [PRIO_W-1:0] tok_out_prio,
  output logic [HND_W-1:0]  tok_out_hnd,
  output logic [IDX_W-1:0]  tok_out_idx
);

  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(POS);
  localparam logic [CNT_W-1:0] NXT_POS = CNT_W'(POS + 1);
  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(POS);

  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [HND_W-1:0]  hnd_r, hnd_nxt;
  logic              found_r, found_nxt;
  logic [PRIO_W-1:0] tprio_r, tprio_nxt;
  logic [HND_W-1:0]  thnd_r, thnd_nxt;
  logic [IDX_W-1:0]  tidx_r, tidx_nxt;
  logic              live;
  logic              take;

  assign live = MY_POS < count;

  // entry update: append at the fill position, or shift down over the gap
  always_comb begin
    prio_nxt = prio_r;
    hnd_nxt  = hnd_r;
    if (ctrl.ins && (MY_POS == count)) begin
      prio_nxt = wr_prio;
      hnd_nxt  = wr_hnd;
    end else if (ctrl.del && (MY_POS >= CNT_W'(sel_idx)) && (NXT_POS < count)) begin
      prio_nxt = nb_prio;
      hnd_nxt  = nb_hnd;
    end
  end

  // running maximum: strictly greater replaces, so the earliest wins on ties
  assign take = live && (!tok_in_found || (prio_r > tok_in_prio));

  always_comb begin
    found_nxt = tok_in_found;
    tprio_nxt = tok_in_prio;
    thnd_nxt  = tok_in_hnd;
    tidx_nxt  = tok_in_idx;
    if (take) begin
      found_nxt = 1'b1;
      tprio_nxt = prio_r;
      thnd_nxt  = hnd_r;
      tidx_nxt  = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r  <= prio_nxt;
    hnd_r   <= hnd_nxt;
    tprio_r <= tprio_nxt;
    thnd_r  <= thnd_nxt;
    tidx_r  <= tidx_nxt;
  end

  assign prio          = prio_r;
  assign hnd           = hnd_r;
  assign tok_out_found = found_r;
  assign tok_out_prio  = tprio_r;
  assign tok_out_hnd   = thnd_r;
  assign tok_out_idx   = tidx_r;

endmodule

// ===== design/bounded_max_priority_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_max_priority_queue - bounded queue with highest-priority removal
// Entries sit in insertion order in a chain of cells; a removal returns the
// highest-priority entry (earliest on ties) and the rest close up.
// ----------------------------------------------------------------------------
// Every accepted transaction yields exactly one result transaction. An insert,
// or a pop on an empty store, gives its result in the cycle after acceptance.
// A pop on a non-empty store runs a search: the controller takes the request,
// a maximum-search token then walks all DEPTH cells of the chain one cell per
// cycle, and a last step removes the winner, shifts the later entries down
// and registers the result; input is held off throughout. A new transaction
// is taken once the controller is idle and the output register is free or
// being drained, so back-to-back inserts run at one per cycle. Capacity is
// written through the APB port at address 0 (reset 16, saturated to DEPTH); a
// status of 1 refuses an insert when full, 2 answers a pop on an empty store.
module bounded_max_priority_queue
  import bmpq_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int PRIO_W = PRIO_W_DEF,
  parameter int HND_W  = HND_W_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input stream
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // tdata: priority_req, handle (zero padded to whole bytes)
  input  logic [((PRIO_W+HND_W+7)/8)*8-1:0]        in_tdata,
  // tuser: req_type
  input  logic                                     in_tuser,
  // result stream
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // tdata: out_priority, out_handle (zero padded to whole bytes)
  output logic [((PRIO_W+HND_W+7)/8)*8-1:0]        out_tdata,
  // tuser: status
  output logic [1:0]                               out_tuser,
  // configuration port
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [2:0]                               cfg_paddr,
  input  logic [31:0]                              cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int DATA_W = ((PRIO_W + HND_W + 7) / 8) * 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] SCAN_LEN = CNT_W'(DEPTH);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(cap_r);

  // --------------------------------------------------------------------------
  // request decode
  // --------------------------------------------------------------------------
  bmpq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;
  logic [PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [HND_W-1:0]  out_hnd_r, out_hnd_nxt;

  logic              in_acc;
  logic [PRIO_W-1:0] req_prio;
  logic [HND_W-1:0]  req_hnd;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  limit;
  logic              full;
  logic              empty;
  logic              scan_done;
  bmpq_ctrl_t        ctrl;
  logic [IDX_W-1:0]  sel_idx;

  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign req_prio  = in_tdata[PRIO_W-1:0];
  assign req_hnd   = in_tdata[PRIO_W+HND_W-1:PRIO_W];

  // capacity saturates to the store depth
  assign cap_ext = CMP_W'(cap_r);
  assign limit   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign full    = CMP_W'(count_r) >= limit;
  assign empty   = count_r == '0;

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  logic [PRIO_W-1:0] c_prio [DEPTH];
  logic [HND_W-1:0]  c_hnd  [DEPTH];
  logic              t_found [DEPTH+1];
  logic [PRIO_W-1:0] t_prio  [DEPTH+1];
  logic [HND_W-1:0]  t_hnd   [DEPTH+1];
  logic [IDX_W-1:0]  t_idx   [DEPTH+1];

  assign t_found[0] = 1'b0;
  assign t_prio[0]  = '0;
  assign t_hnd[0]   = '0;
  assign t_idx[0]   = '0;

  // token at the far end carries the winner once it has crossed every cell
  assign scan_done = (state_r == ST_SCAN) && (scan_cnt_r == SCAN_LEN);
  assign sel_idx   = t_idx[DEPTH];
  assign ctrl.ins  = in_acc && (in_tuser == REQ_INSERT) && !full;
  assign ctrl.del  = scan_done;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [PRIO_W-1:0] nb_prio;
    logic [HND_W-1:0]  nb_hnd;

    if (g == DEPTH - 1) begin : g_top
      assign nb_prio = c_prio[g];
      assign nb_hnd  = c_hnd[g];
    end else begin : g_mid
      assign nb_prio = c_prio[g+1];
      assign nb_hnd  = c_hnd[g+1];
    end

    bmpq_cell #(
      .PRIO_W (PRIO_W),
      .HND_W  (HND_W),
      .IDX_W  (IDX_W),
      .CNT_W  (CNT_W),
      .POS    (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .count         (count_r),
      .sel_idx       (sel_idx),
      .wr_prio       (req_prio),
      .wr_hnd        (req_hnd),
      .nb_prio       (nb_prio),
      .nb_hnd        (nb_hnd),
      .tok_in_found  (t_found[g]),
      .tok_in_prio   (t_prio[g]),
      .tok_in_hnd    (t_hnd[g]),
      .tok_in_idx    (t_idx[g]),
      .prio          (c_prio[g]),
      .hnd           (c_hnd[g]),
      .tok_out_found (t_found[g+1]),
      .tok_out_prio  (t_prio[g+1]),
      .tok_out_hnd   (t_hnd[g+1]),
      .tok_out_idx   (t_idx[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // controller and output register
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_cnt_nxt   = scan_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_stat_nxt   = out_stat_r;
    out_prio_nxt   = out_prio_r;
    out_hnd_nxt    = out_hnd_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_prio_nxt = '0;
          out_hnd_nxt  = '0;
          if (in_tuser == REQ_INSERT) begin
            out_tvalid_nxt = 1'b1;
            out_stat_nxt   = full ? STAT_FULL : STAT_OK;
            if (!full) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (empty) begin
            out_tvalid_nxt = 1'b1;
            out_stat_nxt   = STAT_EMPTY;
          end else begin
            state_nxt    = ST_SCAN;
            scan_cnt_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_done) begin
          state_nxt      = ST_IDLE;
          count_nxt      = count_r - 1'b1;
          out_tvalid_nxt = 1'b1;
          out_stat_nxt   = STAT_OK;
          out_prio_nxt   = t_prio[DEPTH];
          out_hnd_nxt    = t_hnd[DEPTH];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      scan_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_stat_r <= out_stat_nxt;
    out_prio_r <= out_prio_nxt;
    out_hnd_r  <= out_hnd_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = DATA_W'({out_hnd_r, out_prio_r});

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted insert did not grow the count");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (count_r != '0) && t_found[DEPTH] || (scan_cnt_r != SCAN_LEN))
    else $error("search finished without a winner");

  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> out_tvalid && (out_tuser == STAT_OK) && (state_r == ST_IDLE))
    else $error("pop result not presented after the search");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(DEPTH)) && !(out_tvalid && (out_tuser == STAT_FULL) &&
    (out_tdata != '0)))
    else $error("count beyond depth or refused insert with payload");

endmodule
